### src/magnetometer_gain_cal_and_field_change_macros.svh
// Assertion macros shared by the magnetometer calibration block.
// Stand-alone header; the files that assert include it by name.
`ifndef MAGNETOMETER_GAIN_CAL_AND_FIELD_CHANGE_MACROS_SVH
`define MAGNETOMETER_GAIN_CAL_AND_FIELD_CHANGE_MACROS_SVH
`ifndef SYNTHESIS
`define MGCFC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mgcfc assertion failed");
`define MGCFC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mgcfc assertion failed");
`else
`define MGCFC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MGCFC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### src/mgcfc_pkg.sv
// Shared types and constants of the magnetometer calibration block.
// No dependencies; every other file but mgcfc_chan_if and the macro header imports it.
package mgcfc_pkg;

   localparam int GAIN_FRAC_BITS = 12;
   localparam int MAG_FRAC_BITS  = 8;
   localparam int SQ_W           = 32 + 2 * MAG_FRAC_BITS;
   localparam int ROOT_W         = 16 + MAG_FRAC_BITS;
   localparam int DIV_W          = 32;
   localparam int CNT_W          = 5;
   localparam int Q_DEPTH        = 2;
   localparam int Q_PTR_W        = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_FILL_W       = $clog2(Q_DEPTH + 1);

   localparam logic [23:0] MAX24      = 24'hFFFFFF;
   localparam logic [23:0] GAIN_UNITY = 24'(1 << GAIN_FRAC_BITS);

   localparam logic [1:0] CMD_CAL  = 2'd0;
   localparam logic [1:0] CMD_FIN  = 2'd1;
   localparam logic [1:0] CMD_BASE = 2'd2;
   localparam logic [1:0] CMD_MEAS = 2'd3;

   localparam logic [1:0] STS_OK     = 2'd0;
   localparam logic [1:0] STS_REJECT = 2'd1;
   localparam logic [1:0] STS_EMPTY  = 2'd2;

   localparam logic [1:0] REG_WINDOW_LOW  = 2'd0;
   localparam logic [1:0] REG_WINDOW_HIGH = 2'd1;
   localparam logic [1:0] REG_TARGET_XY   = 2'd2;
   localparam logic [1:0] REG_TARGET_Z    = 2'd3;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [2:0]         sensor_index;
      logic signed [15:0] raw_x;
      logic signed [15:0] raw_y;
      logic signed [15:0] raw_z;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [23:0]        field_change;
      logic signed [15:0] scaled_x;
      logic signed [15:0] scaled_y;
      logic signed [15:0] scaled_z;
      logic [7:0]         accepted_count;
   } rsp_payload_type;

   typedef struct packed {
      req_payload_type pay;
      logic            sensor_ok;
      logic            win_ok;
   } q_item_type;

endpackage

### src/mgcfc_chan_if.sv
// Valid/ready channel carrying one word of a given payload type.
// No dependencies.
interface mgcfc_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### src/mgcfc_front.sv
// Front end: takes request words and classifies sensor index and window.
// Depends on mgcfc_pkg and mgcfc_chan_if.
module mgcfc_front #(
   parameter int NUM_SENSORS = 7
) (
   mgcfc_chan_if.sink           req,
   input  logic [14:0]          window_low,
   input  logic [14:0]          window_high,
   input  logic                 push_ready,
   output logic                 push_valid,
   output mgcfc_pkg::q_item_type push_item
);
   import mgcfc_pkg::*;

   logic in_x, in_y, in_z;

   function automatic logic in_win(logic signed [15:0] v, logic [14:0] lo, logic [14:0] hi);
      logic signed [15:0] slo;
      logic signed [15:0] shi;
      slo = $signed({1'b0, lo});
      shi = $signed({1'b0, hi});
      return (v > slo) && (v < shi);
   endfunction

   always_comb begin
      in_x = in_win(req.payload.raw_x, window_low, window_high);
      in_y = in_win(req.payload.raw_y, window_low, window_high);
      in_z = in_win(req.payload.raw_z, window_low, window_high);
      push_item.pay       = req.payload;
      push_item.sensor_ok = int'(req.payload.sensor_index) < NUM_SENSORS;
      push_item.win_ok    = in_x && in_y && in_z;
   end

   assign push_valid = req.valid;
   assign req.ready  = push_ready;

endmodule

### src/mgcfc_queue.sv
// Short queue of classified words between the front and back ends.
// Depends on mgcfc_pkg.
module mgcfc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  mgcfc_pkg::q_item_type push_item,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output mgcfc_pkg::q_item_type pop_item
);
   import mgcfc_pkg::*;

   q_item_type          mem_ff [Q_DEPTH];
   q_item_type          mem_in [Q_DEPTH];
   logic [Q_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [Q_FILL_W-1:0] fill_ff, fill_in;
   logic                do_push, do_pop;

   assign push_ready = fill_ff != Q_FILL_W'(Q_DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      mem_in    = mem_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         mem_in[wr_ptr_ff] = push_item;
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      mem_ff <= mem_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### src/mgcfc_back.sv
// Back end: per-sensor state, shared multiplier, restoring divider, bit-pair
// square root and output register. Needs mgcfc_pkg, mgcfc_chan_if, macro header.
`include "magnetometer_gain_cal_and_field_change_macros.svh"
module mgcfc_back #(
   parameter int NUM_SENSORS = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  mgcfc_pkg::q_item_type q_item,
   input  logic [11:0]           target_xy,
   input  logic [11:0]           target_z,
   mgcfc_chan_if.source          rsp
);
   import mgcfc_pkg::*;

   localparam int SW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_DIV     = 8'b0000_0010,
      ST_SCL_MUL = 8'b0000_0100,
      ST_SCL_SAT = 8'b0000_1000,
      ST_SQ_MUL  = 8'b0001_0000,
      ST_SQ_ACC  = 8'b0010_0000,
      ST_SQRT    = 8'b0100_0000,
      ST_DONE    = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   q_item_type         item_ff, item_in;
   logic [31:0]        sum_ff [NUM_SENSORS][3];
   logic [31:0]        sum_in [NUM_SENSORS][3];
   logic [23:0]        gain_ff [NUM_SENSORS][3];
   logic [23:0]        gain_in [NUM_SENSORS][3];
   logic [7:0]         count_ff [NUM_SENSORS];
   logic [7:0]         count_in [NUM_SENSORS];
   logic [23:0]        base_ff [NUM_SENSORS];
   logic [23:0]        base_in [NUM_SENSORS];
   logic signed [15:0] scl_ff [3];
   logic signed [15:0] scl_in [3];
   logic [1:0]         status_ff, status_in;
   logic [23:0]        change_ff, change_in;
   logic [7:0]         acc_ff, acc_in;
   logic [1:0]         axis_ff, axis_in;
   logic               div_gain_ff, div_gain_in;
   logic [31:0]        div_n_ff, div_n_in;
   logic [31:0]        div_d_ff, div_d_in;
   logic [31:0]        div_r_ff, div_r_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [40:0]        prod_ff, prod_in;
   logic [31:0]        ss_ff, ss_in;
   logic [SQ_W-1:0]    sq_v_ff, sq_v_in;
   logic [ROOT_W+1:0]  sq_rem_ff, sq_rem_in;
   logic [ROOT_W-1:0]  sq_root_ff, sq_root_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_pay_ff, rsp_pay_in;

   logic [SW-1:0]      q_sid, sid;
   logic [7:0]         q_cnt;
   logic signed [15:0] raw_sel;
   logic [16:0]        mul_a;
   logic [23:0]        mul_b;

   assign q_sid = SW'(q_item.pay.sensor_index);
   assign sid   = SW'(item_ff.pay.sensor_index);
   assign q_cnt = count_ff[q_sid];

   always_comb begin
      case (axis_ff)
         2'd0:    raw_sel = item_ff.pay.raw_x;
         2'd1:    raw_sel = item_ff.pay.raw_y;
         default: raw_sel = item_ff.pay.raw_z;
      endcase
   end

   // One multiplier serves both the gain scaling and the squaring.
   always_comb begin
      logic signed [16:0] sx;
      sx = (state_ff == ST_SQ_MUL) ? {scl_ff[axis_ff][15], scl_ff[axis_ff]}
                                   : {raw_sel[15], raw_sel};
      mul_a = sx[16] ? 17'(17'd0 - sx) : 17'(sx);
      mul_b = (state_ff == ST_SQ_MUL) ? 24'(mul_a) : gain_ff[sid][axis_ff];
   end

   always_comb begin
      logic [32:0]       rsh;
      logic [32:0]       rdiff;
      logic              ge;
      logic [31:0]       quo;
      logic              next_axis;
      logic [31:0]       num_t;
      logic [28:0]       smag;
      logic [31:0]       ss_nx;
      logic [ROOT_W+1:0] rem_t;
      logic [ROOT_W+1:0] trial;
      logic [ROOT_W-1:0] root_nx;
      logic [31:0]       mag32;
      logic [23:0]       mag;

      state_in    = state_ff;
      item_in     = item_ff;
      sum_in      = sum_ff;
      gain_in     = gain_ff;
      count_in    = count_ff;
      base_in     = base_ff;
      scl_in      = scl_ff;
      status_in   = status_ff;
      change_in   = change_ff;
      acc_in      = acc_ff;
      axis_in     = axis_ff;
      div_gain_in = div_gain_ff;
      div_n_in    = div_n_ff;
      div_d_in    = div_d_ff;
      div_r_in    = div_r_ff;
      cnt_in      = cnt_ff;
      prod_in     = prod_ff;
      ss_in       = ss_ff;
      sq_v_in     = sq_v_ff;
      sq_rem_in   = sq_rem_ff;
      sq_root_in  = sq_root_ff;
      rsp_pay_in  = rsp_pay_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      q_pop       = 1'b0;

      rsh   = {div_r_ff, div_n_ff[31]};
      rdiff = rsh - {1'b0, div_d_ff};
      ge    = rsh >= {1'b0, div_d_ff};
      quo   = {div_n_ff[30:0], ge};
      next_axis = 1'b0;
      num_t = (axis_ff == 2'd2) ? (32'(target_z) << GAIN_FRAC_BITS)
                                : (32'(target_xy) << GAIN_FRAC_BITS);
      smag  = 29'(prod_ff >> GAIN_FRAC_BITS);
      ss_nx = ss_ff + prod_ff[31:0];
      rem_t = {sq_rem_ff[ROOT_W-1:0], sq_v_ff[SQ_W-1 -: 2]};
      trial = {sq_root_ff, 2'b01};
      root_nx = (rem_t >= trial) ? {sq_root_ff[ROOT_W-2:0], 1'b1}
                                 : {sq_root_ff[ROOT_W-2:0], 1'b0};
      mag32 = 32'(root_nx);
      mag   = (mag32 > 32'(MAX24)) ? MAX24 : mag32[23:0];

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               item_in   = q_item;
               status_in = STS_OK;
               change_in = '0;
               acc_in    = '0;
               axis_in   = '0;
               for (int a = 0; a < 3; a++) begin
                  scl_in[a] = '0;
               end
               if (!q_item.sensor_ok) begin
                  state_in = ST_DONE;
               end else begin
                  case (q_item.pay.cmd)
                     CMD_CAL: begin
                        if (q_item.win_ok && q_cnt != 8'hFF) begin
                           sum_in[q_sid][0] = sum_ff[q_sid][0] + 32'($unsigned(q_item.pay.raw_x));
                           sum_in[q_sid][1] = sum_ff[q_sid][1] + 32'($unsigned(q_item.pay.raw_y));
                           sum_in[q_sid][2] = sum_ff[q_sid][2] + 32'($unsigned(q_item.pay.raw_z));
                           count_in[q_sid] = q_cnt + 8'd1;
                           acc_in = q_cnt + 8'd1;
                        end else begin
                           status_in = STS_REJECT;
                           acc_in = q_cnt;
                        end
                        state_in = ST_DONE;
                     end
                     CMD_FIN: begin
                        acc_in = q_cnt;
                        if (q_cnt == 8'd0) begin
                           status_in = STS_EMPTY;
                           for (int a = 0; a < 3; a++) begin
                              sum_in[q_sid][a] = '0;
                           end
                           state_in = ST_DONE;
                        end else begin
                           div_n_in    = sum_ff[q_sid][0];
                           div_d_in    = {24'd0, q_cnt};
                           div_r_in    = '0;
                           cnt_in      = CNT_W'(DIV_W - 1);
                           div_gain_in = 1'b0;
                           state_in    = ST_DIV;
                        end
                     end
                     default: begin
                        acc_in   = q_cnt;
                        state_in = ST_SCL_MUL;
                     end
                  endcase
               end
            end
         end
         ST_DIV: begin
            div_r_in = ge ? rdiff[31:0] : rsh[31:0];
            div_n_in = quo;
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (!div_gain_ff) begin
                  // A zero mean gives the largest gain rather than a division.
                  if (quo == '0) begin
                     gain_in[sid][axis_ff] = MAX24;
                     next_axis = 1'b1;
                  end else begin
                     div_n_in    = num_t;
                     div_d_in    = quo;
                     div_r_in    = '0;
                     cnt_in      = CNT_W'(DIV_W - 1);
                     div_gain_in = 1'b1;
                  end
               end else begin
                  gain_in[sid][axis_ff] = (quo > 32'(MAX24)) ? MAX24 : quo[23:0];
                  next_axis = 1'b1;
               end
               if (next_axis) begin
                  if (axis_ff == 2'd2) begin
                     for (int a = 0; a < 3; a++) begin
                        sum_in[sid][a] = '0;
                     end
                     count_in[sid] = '0;
                     state_in = ST_DONE;
                  end else begin
                     axis_in     = axis_ff + 2'd1;
                     div_n_in    = sum_ff[sid][axis_ff + 2'd1];
                     div_d_in    = {24'd0, count_ff[sid]};
                     div_r_in    = '0;
                     cnt_in      = CNT_W'(DIV_W - 1);
                     div_gain_in = 1'b0;
                  end
               end
            end
         end
         ST_SCL_MUL: begin
            prod_in  = 41'(mul_a) * 41'(mul_b);
            state_in = ST_SCL_SAT;
         end
         ST_SCL_SAT: begin
            if (raw_sel[15]) begin
               scl_in[axis_ff] = (smag > 29'd32768) ? 16'sh8000 : $signed(16'd0 - smag[15:0]);
            end else begin
               scl_in[axis_ff] = (smag > 29'd32767) ? 16'sh7FFF : $signed(smag[15:0]);
            end
            if (axis_ff == 2'd2) begin
               axis_in  = '0;
               ss_in    = '0;
               state_in = ST_SQ_MUL;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_SCL_MUL;
            end
         end
         ST_SQ_MUL: begin
            prod_in  = 41'(mul_a) * 41'(mul_b);
            state_in = ST_SQ_ACC;
         end
         ST_SQ_ACC: begin
            ss_in = ss_nx;
            if (axis_ff == 2'd2) begin
               sq_v_in    = SQ_W'(ss_nx) << (2 * MAG_FRAC_BITS);
               sq_rem_in  = '0;
               sq_root_in = '0;
               cnt_in     = CNT_W'(ROOT_W - 1);
               state_in   = ST_SQRT;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_SQ_MUL;
            end
         end
         ST_SQRT: begin
            // One result bit per cycle, two radicand bits brought down each time.
            sq_rem_in  = (rem_t >= trial) ? rem_t - trial : rem_t;
            sq_root_in = root_nx;
            sq_v_in    = sq_v_ff << 2;
            cnt_in     = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (item_ff.pay.cmd == CMD_BASE) begin
                  base_in[sid] = mag;
               end else begin
                  change_in = (mag >= base_ff[sid]) ? mag - base_ff[sid] : base_ff[sid] - mag;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in               = 1'b1;
               rsp_pay_in.status          = status_ff;
               rsp_pay_in.field_change    = change_ff;
               rsp_pay_in.scaled_x        = scl_ff[0];
               rsp_pay_in.scaled_y        = scl_ff[1];
               rsp_pay_in.scaled_z        = scl_ff[2];
               rsp_pay_in.accepted_count  = acc_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      scl_ff      <= scl_in;
      status_ff   <= status_in;
      change_ff   <= change_in;
      acc_ff      <= acc_in;
      axis_ff     <= axis_in;
      div_gain_ff <= div_gain_in;
      div_n_ff    <= div_n_in;
      div_d_ff    <= div_d_in;
      div_r_ff    <= div_r_in;
      cnt_ff      <= cnt_in;
      prod_ff     <= prod_in;
      ss_ff       <= ss_in;
      sq_v_ff     <= sq_v_in;
      sq_rem_ff   <= sq_rem_in;
      sq_root_ff  <= sq_root_in;
      rsp_pay_ff  <= rsp_pay_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SENSORS; i++) begin
            for (int a = 0; a < 3; a++) begin
               sum_ff[i][a]  <= '0;
               gain_ff[i][a] <= GAIN_UNITY;
            end
            count_ff[i] <= '0;
            base_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
         gain_ff      <= gain_in;
         count_ff     <= count_in;
         base_ff      <= base_in;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_pay_ff;

   `MGCFC_ASSERT_IMP(a_empty_has_no_count, clock, reset,
      rsp_valid_ff && rsp_pay_ff.status == STS_EMPTY, rsp_pay_ff.accepted_count == 8'd0)
   `MGCFC_ASSERT_IMP(a_error_word_is_clear, clock, reset,
      rsp_valid_ff && rsp_pay_ff.status != STS_OK,
      rsp_pay_ff.scaled_x == 16'sd0 && rsp_pay_ff.scaled_y == 16'sd0 &&
      rsp_pay_ff.scaled_z == 16'sd0 && rsp_pay_ff.field_change == 24'd0)
   `MGCFC_ASSERT_NEXT(a_pop_starts_work, clock, reset, q_pop, state_ff != ST_IDLE)

endmodule

### src/magnetometer_gain_cal_and_field_change.sv
// Calibration and field-change block for up to NUM_SENSORS three-axis magnetometers.
// A calibration sample, or a word for a sensor index out of range, uses neither
// multiplier, divider nor root; a baseline or measure word passes through the
// shared multiplier (six passes) and the 24-step bit-pair square root; a finish
// word with samples runs the shared 32-step restoring divider twice per axis,
// or once where the mean is zero. A two-word queue sits between the request
// side and the arithmetic, and the response has its own output register.
// Depends on mgcfc_pkg, mgcfc_chan_if, mgcfc_front, mgcfc_queue and mgcfc_back.
module magnetometer_gain_cal_and_field_change #(
   parameter int NUM_SENSORS = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wdata,
   mgcfc_chan_if.sink  req,
   mgcfc_chan_if.source rsp
);
   import mgcfc_pkg::*;

   logic [14:0] window_low_ff, window_low_in;
   logic [14:0] window_high_ff, window_high_in;
   logic [11:0] target_xy_ff, target_xy_in;
   logic [11:0] target_z_ff, target_z_in;

   logic       push_valid, push_ready, pop_valid, pop_ready;
   q_item_type push_item, pop_item;

   always_comb begin
      window_low_in  = window_low_ff;
      window_high_in = window_high_ff;
      target_xy_in   = target_xy_ff;
      target_z_in    = target_z_ff;
      if (csr_we) begin
         case (csr_index)
            REG_WINDOW_LOW:  window_low_in  = csr_wdata;
            REG_WINDOW_HIGH: window_high_in = csr_wdata;
            REG_TARGET_XY:   target_xy_in   = csr_wdata[11:0];
            REG_TARGET_Z:    target_z_in    = csr_wdata[11:0];
            default:         window_low_in  = window_low_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_low_ff  <= 15'd161;
         window_high_ff <= 15'd310;
         target_xy_ff   <= 12'd1080;
         target_z_ff    <= 12'd1160;
      end else begin
         window_low_ff  <= window_low_in;
         window_high_ff <= window_high_in;
         target_xy_ff   <= target_xy_in;
         target_z_ff    <= target_z_in;
      end
   end

   mgcfc_front #(.NUM_SENSORS(NUM_SENSORS)) u_front (
      .req         (req),
      .window_low  (window_low_ff),
      .window_high (window_high_ff),
      .push_ready  (push_ready),
      .push_valid  (push_valid),
      .push_item   (push_item)
   );

   mgcfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   mgcfc_back #(.NUM_SENSORS(NUM_SENSORS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (pop_valid),
      .q_pop     (pop_ready),
      .q_item    (pop_item),
      .target_xy (target_xy_ff),
      .target_z  (target_z_ff),
      .rsp       (rsp)
   );

endmodule

### tb/magnetometer_gain_cal_and_field_change_test.sv
// Testbench for the magnetometer gain calibration and field-change block.
// Drives words through the request channel and checks every response against a
// built-in predictor of the block. Depends on mgcfc_pkg, mgcfc_chan_if and the RTL.
`timescale 1ns / 1ps

module magnetometer_gain_cal_and_field_change_test;
   import mgcfc_pkg::*;

   localparam int SENSORS    = 7;
   localparam int STALL_LIMIT = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = REG_WINDOW_LOW;
   logic [14:0] csr_wdata = '0;

   mgcfc_chan_if #(.payload_type(req_payload_type)) req_ch ();
   mgcfc_chan_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   magnetometer_gain_cal_and_field_change #(.NUM_SENSORS(SENSORS)) u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_ch.sink),
      .rsp       (rsp_ch.source)
   );

   always #5 clock = ~clock;

   // Predictor state: the register copies, then one entry per sensor.
   int unsigned win_lo, win_hi, tgt_xy, tgt_z;
   int unsigned acc_x [SENSORS], acc_y [SENSORS], acc_z [SENSORS];
   int unsigned acc_n [SENSORS];
   int unsigned gain_x [SENSORS], gain_y [SENSORS], gain_z [SENSORS];
   int unsigned base_mag [SENSORS];

   rsp_payload_type expected_rsp [$];
   int  errors = 0;
   int  words_sent = 0, rsp_seen = 0, rejects_seen = 0, empties_seen = 0;
   int  idle_pct = 29, stall_pct = 29;
   int  quiet_cycles = 0;
   bit  no_idle = 1'b0;

   function automatic bit axis_ok(logic signed [15:0] v);
      return int'(v) > int'(win_lo) && int'(v) < int'(win_hi);
   endfunction

   function automatic int unsigned calc_gain(int unsigned tgt, int unsigned sum,
                                             int unsigned n);
      longint unsigned mean, g;
      mean = longint'(sum) / n;
      if (mean == 0) return 32'hFFFFFF;
      g = (longint'(tgt) << GAIN_FRAC_BITS) / mean;
      return (g > 64'hFFFFFF) ? 32'hFFFFFF : int'(g);
   endfunction

   function automatic logic signed [15:0] apply_gain(logic signed [15:0] raw,
                                                    int unsigned g);
      longint unsigned m;
      bit neg;
      neg = raw < 0;
      m = longint'(neg ? -int'(raw) : int'(raw)) * longint'(g);
      m = m >> GAIN_FRAC_BITS;
      if (neg) return (m > 32768) ? -16'sd32768 : 16'(-longint'(m));
      return (m > 32767) ? 16'sd32767 : 16'(m);
   endfunction

   function automatic int unsigned field_magnitude(logic signed [15:0] x,
                                                   logic signed [15:0] y,
                                                   logic signed [15:0] z);
      longint unsigned v, root, b;
      v = longint'(longint'(x) * x) + longint'(longint'(y) * y)
        + longint'(longint'(z) * z);
      v = v << (2 * MAG_FRAC_BITS);
      root = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= root + b) begin
            v = v - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return (root > 64'hFFFFFF) ? 32'hFFFFFF : int'(root);
   endfunction

   // Works out the response to one accepted word and updates the sensor state.
   function automatic rsp_payload_type predict_response(req_payload_type w);
      rsp_payload_type r;
      int s;
      int unsigned m;
      r = '0;
      s = w.sensor_index;
      if (s >= SENSORS) return r;
      case (w.cmd)
         CMD_CAL: begin
            if (axis_ok(w.raw_x) && axis_ok(w.raw_y) && axis_ok(w.raw_z)
                && acc_n[s] < 255) begin
               acc_x[s] += int'(w.raw_x);
               acc_y[s] += int'(w.raw_y);
               acc_z[s] += int'(w.raw_z);
               acc_n[s]++;
            end else begin
               r.status = STS_REJECT;
            end
            r.accepted_count = acc_n[s];
         end
         CMD_FIN: begin
            r.accepted_count = acc_n[s];
            if (acc_n[s] == 0) begin
               r.status = STS_EMPTY;
            end else begin
               gain_x[s] = calc_gain(tgt_xy, acc_x[s], acc_n[s]);
               gain_y[s] = calc_gain(tgt_xy, acc_y[s], acc_n[s]);
               gain_z[s] = calc_gain(tgt_z, acc_z[s], acc_n[s]);
            end
            acc_x[s] = 0; acc_y[s] = 0; acc_z[s] = 0; acc_n[s] = 0;
         end
         default: begin
            r.scaled_x = apply_gain(w.raw_x, gain_x[s]);
            r.scaled_y = apply_gain(w.raw_y, gain_y[s]);
            r.scaled_z = apply_gain(w.raw_z, gain_z[s]);
            m = field_magnitude(r.scaled_x, r.scaled_y, r.scaled_z);
            if (w.cmd == CMD_BASE) base_mag[s] = m;
            else r.field_change = (m >= base_mag[s]) ? m - base_mag[s] : base_mag[s] - m;
            r.accepted_count = acc_n[s];
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("mismatch on response %0d: %s got %0d, wanted %0d", rsp_seen, what, got, want);
   endtask

   // Sends one word, waiting out a random idle gap first.
   task automatic send_word(logic [1:0] cmd, logic [2:0] s, logic signed [15:0] x,
                            logic signed [15:0] y, logic signed [15:0] z);
      req_payload_type w;
      w = '{cmd: cmd, sensor_index: s, raw_x: x, raw_y: y, raw_z: z};
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid   = 1'b1;
      req_ch.payload = w;
      do @(posedge clock); while (!req_ch.ready);
      expected_rsp.push_back(predict_response(w));
      words_sent++;
   endtask

   task automatic idle_request();
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   task automatic write_register(logic [1:0] idx, int unsigned value);
      idle_request();
      wait (expected_rsp.size() == 0);
      repeat (8) @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = 15'(value);
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         REG_WINDOW_LOW:  win_lo = value & 32'h7FFF;
         REG_WINDOW_HIGH: win_hi = value & 32'h7FFF;
         REG_TARGET_XY:   tgt_xy = value & 32'hFFF;
         default:         tgt_z  = value & 32'hFFF;
      endcase
   endtask

   task automatic write_all(int unsigned lo, int unsigned hi, int unsigned txy,
                            int unsigned tz);
      write_register(REG_WINDOW_LOW, lo);
      write_register(REG_WINDOW_HIGH, hi);
      write_register(REG_TARGET_XY, txy);
      write_register(REG_TARGET_Z, tz);
   endtask

   function automatic logic signed [15:0] in_window_value();
      return 16'($urandom_range(win_lo + 1, win_hi - 1));
   endfunction

   function automatic logic signed [15:0] any_value();
      case ($urandom_range(3))
         0:       return 16'($urandom);
         1:       return 16'($urandom_range(0, 600));
         2:       return -16'sd1 * 16'($urandom_range(0, 600));
         default: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      endcase
   endfunction

   task automatic test_directed();
      // Reset values: unity gains, zero baseline, default window.
      send_word(CMD_BASE, 3'd0, 16'sh7FFF, 16'sh8000, 16'sd0);
      send_word(CMD_MEAS, 3'd0, 16'sh8000, 16'sh8000, 16'sh8000);
      send_word(CMD_MEAS, 3'd1, 16'sd0, 16'sd0, 16'sd0);
      send_word(CMD_FIN, 3'd2, 16'sd0, 16'sd0, 16'sd0);
      // Window edges are exclusive.
      send_word(CMD_CAL, 3'd2, 16'sd161, 16'sd200, 16'sd200);
      send_word(CMD_CAL, 3'd2, 16'sd200, 16'sd310, 16'sd200);
      send_word(CMD_CAL, 3'd2, 16'sd200, 16'sd200, -16'sd200);
      send_word(CMD_CAL, 3'd2, 16'sd162, 16'sd309, 16'sd250);
      send_word(CMD_CAL, 3'd2, 16'sd309, 16'sd162, 16'sd251);
      send_word(CMD_FIN, 3'd2, 16'sd0, 16'sd0, 16'sd0);
      send_word(CMD_BASE, 3'd2, 16'sd300, -16'sd300, 16'sd300);
      send_word(CMD_MEAS, 3'd2, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      // Sensor index out of range leaves everything alone.
      send_word(CMD_CAL, 3'd7, 16'sd200, 16'sd200, 16'sd200);
      send_word(CMD_FIN, 3'd7, 16'sd0, 16'sd0, 16'sd0);
      send_word(CMD_BASE, 3'd7, 16'sd5, 16'sd5, 16'sd5);
      send_word(CMD_MEAS, 3'd7, 16'sd5, 16'sd5, 16'sd5);
      // Widest window, highest targets, smallest mean: gains become very large.
      write_all(1, 32767, 4095, 4095);
      send_word(CMD_CAL, 3'd6, 16'sd2, 16'sd2, 16'sd2);
      send_word(CMD_FIN, 3'd6, 16'sd0, 16'sd0, 16'sd0);
      send_word(CMD_BASE, 3'd6, 16'sh7FFF, 16'sh8000, 16'sd1);
      send_word(CMD_MEAS, 3'd6, -16'sd1, 16'sd0, 16'sd3);
      // Smallest targets and largest mean: gains fall to nothing.
      write_all(32765, 32767, 1, 1);
      send_word(CMD_CAL, 3'd5, 16'sd32766, 16'sd32766, 16'sd32766);
      send_word(CMD_FIN, 3'd5, 16'sd0, 16'sd0, 16'sd0);
      send_word(CMD_MEAS, 3'd5, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
   endtask

   task automatic test_count_full();
      write_all(1, 32767, 1080, 1160);
      // The 256th sample in the window must be turned away.
      for (int i = 0; i < 257; i++)
         send_word(CMD_CAL, 3'd4, 16'($urandom_range(2, 32766)),
                   16'($urandom_range(2, 32766)), 16'($urandom_range(2, 32766)));
      send_word(CMD_FIN, 3'd4, 16'sd0, 16'sd0, 16'sd0);
      send_word(CMD_MEAS, 3'd4, 16'sd1000, -16'sd1000, 16'sd1000);
   endtask

   task automatic random_configuration();
      int unsigned lo, hi;
      case ($urandom_range(3))
         0: begin lo = 161; hi = 310; end
         1: begin lo = 1; hi = 32767; end
         2: begin lo = $urandom_range(1, 30000); hi = lo + $urandom_range(2, 2000); end
         default: begin lo = $urandom_range(1, 200); hi = lo + $urandom_range(2, 40); end
      endcase
      if (hi > 32767) hi = 32767;
      write_all(lo, hi, $urandom_range(1) ? $urandom_range(1, 4095) : 4095,
                $urandom_range(3) ? $urandom_range(1, 4095) : 1);
   endtask

   // Mostly whole calibrate, finish, baseline and measure sequences per sensor.
   // A stretch in the middle runs with no idling on either side.
   task automatic test_random(int target_words);
      int s, n;
      while (words_sent < target_words) begin
         if ($urandom_range(5) == 0) random_configuration();
         no_idle  = (words_sent >= 600) && (words_sent < 800);
         idle_pct = (no_idle || $urandom_range(7) == 0) ? 0 : 29;
         s = ($urandom_range(15) == 0) ? 7 : $urandom_range(SENSORS - 1);
         n = $urandom_range(0, 12);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(5) == 0)
               send_word(CMD_CAL, 3'(s), any_value(), any_value(), any_value());
            else
               send_word(CMD_CAL, 3'(s), in_window_value(), in_window_value(),
                         in_window_value());
         end
         if ($urandom_range(7) != 0) send_word(CMD_FIN, 3'(s), any_value(), any_value(),
                                               any_value());
         send_word(CMD_BASE, 3'(s), any_value(), any_value(), any_value());
         n = $urandom_range(1, 5);
         for (int i = 0; i < n; i++)
            send_word(2'($urandom_range(3)), 3'($urandom_range(7)), any_value(),
                      any_value(), any_value());
      end
      no_idle  = 1'b0;
      idle_pct = 29;
   endtask

   always @(negedge clock) begin
      if ($urandom_range(199) == 0) stall_pct = $urandom_range(1) ? 0 : 29;
      rsp_ch.ready <= no_idle || ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_seen++;
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("response %0d arrived with nothing expected", rsp_seen);
         end else begin
            rsp_payload_type e;
            rsp_payload_type g;
            e = expected_rsp.pop_front();
            g = rsp_ch.payload;
            if (e.status == STS_REJECT) rejects_seen++;
            if (e.status == STS_EMPTY) empties_seen++;
            if (g.status !== e.status) report_mismatch("status", g.status, e.status);
            if (g.field_change !== e.field_change)
               report_mismatch("field_change", g.field_change, e.field_change);
            if (g.scaled_x !== e.scaled_x) report_mismatch("scaled_x", g.scaled_x, e.scaled_x);
            if (g.scaled_y !== e.scaled_y) report_mismatch("scaled_y", g.scaled_y, e.scaled_y);
            if (g.scaled_z !== e.scaled_z) report_mismatch("scaled_z", g.scaled_z, e.scaled_z);
            if (g.accepted_count !== e.accepted_count)
               report_mismatch("accepted_count", g.accepted_count, e.accepted_count);
         end
      end
   end

   // Ends the run if neither channel moves a word for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("no progress for %0d cycles, %0d responses outstanding",
                  STALL_LIMIT, expected_rsp.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      win_lo = 161; win_hi = 310; tgt_xy = 1080; tgt_z = 1160;
      for (int i = 0; i < SENSORS; i++) begin
         acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0; acc_n[i] = 0;
         gain_x[i] = 4096; gain_y[i] = 4096; gain_z[i] = 4096;
         base_mag[i] = 0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_count_full();
      test_random(1150);
      idle_request();
      wait (expected_rsp.size() == 0);
      repeat (300) @(posedge clock);
      $display("%0d words sent, %0d responses checked (%0d rejected samples,",
               words_sent, rsp_seen, rejects_seen);
      $display("%0d empty finishes), %0d mismatches", empties_seen, errors);
      if (errors == 0 && expected_rsp.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### magnetometer_gain_cal_and_field_change.f
+incdir+src
src/mgcfc_pkg.sv
src/mgcfc_chan_if.sv
src/mgcfc_front.sv
src/mgcfc_queue.sv
src/mgcfc_back.sv
src/magnetometer_gain_cal_and_field_change.sv
tb/magnetometer_gain_cal_and_field_change_test.sv
